// ===== rtl/gda_pkg.sv =====
package gda_pkg;

    // Day counts of the Gregorian cycles
    localparam int unsigned DAYS_PER_400Y = 146097;
    localparam int unsigned DAYS_PER_100Y = 36524;
    localparam int unsigned DAYS_PER_4Y   = 1461;
    localparam int unsigned DAYS_PER_Y    = 365;

    // Reciprocals for division by constants
    // ceil(2^17 / 25): exact floor for any 12-bit dividend
    localparam logic [12:0] RECIP_25           = 13'd5243;
    localparam int          RECIP_25_SHIFT     = 17;
    // floor(2^31 / 146097): estimate is the quotient or one below it
    localparam logic [13:0] RECIP_400Y         = 14'd14699;
    localparam int          RECIP_400Y_SHIFT   = 31;
    // ceil(2^26 / 1461): exact floor for dividends below 2^16
    localparam logic [15:0] RECIP_4Y           = 16'd45934;
    localparam int          RECIP_4Y_SHIFT     = 26;

    localparam int SERIAL_W = 24;

    typedef enum logic [1:0] {
        STATUS_OK       = 2'd0,
        STATUS_BAD_DATE = 2'd1,
        STATUS_RANGE    = 2'd2
    } status_t;

    // Day number counted from 0001-01-01
    typedef struct packed {
        logic                valid;
        logic                bad;
        logic [SERIAL_W-1:0] serial;
    } day_num_t;

    // Day number broken into cycle counts and day of year
    typedef struct packed {
        logic       valid;
        logic       bad;
        logic [6:0] q400;
        logic [1:0] cent;
        logic [4:0] quad;
        logic [1:0] yr;
        logic [8:0] doy;
    } ydec_t;

    typedef struct packed {
        logic        valid;
        status_t     status;
        logic [4:0]  day;
        logic [3:0]  month;
        logic [13:0] year;
    } result_t;

    // Days before the month, zero-based month index
    function automatic logic [8:0] month_start(input logic [3:0] mon_idx, input logic leap);
        logic [8:0] base;
        case (mon_idx)
            4'd0:    base = 9'd0;
            4'd1:    base = 9'd31;
            4'd2:    base = 9'd59;
            4'd3:    base = 9'd90;
            4'd4:    base = 9'd120;
            4'd5:    base = 9'd151;
            4'd6:    base = 9'd181;
            4'd7:    base = 9'd212;
            4'd8:    base = 9'd243;
            4'd9:    base = 9'd273;
            4'd10:   base = 9'd304;
            4'd11:   base = 9'd334;
            default: base = 9'd0;
        endcase
        month_start = base + ((leap && (mon_idx > 4'd1)) ? 9'd1 : 9'd0);
    endfunction

    // Length of the month, one-based month
    function automatic logic [4:0] month_len(input logic [3:0] mon, input logic leap);
        logic [4:0] len;
        case (mon)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
            4'd2:    len = leap ? 5'd29 : 5'd28;
            default: len = 5'd0;
        endcase
        month_len = len;
    endfunction

endpackage

// ===== rtl/gda_serial.sv =====
module gda_serial
    import gda_pkg::*;
#(
    parameter int unsigned MAX_YEAR = 9999
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        advance,
    input  logic        in_valid,
    input  logic [13:0] in_year,
    input  logic [3:0]  in_month,
    input  logic [4:0]  in_day,
    input  logic [21:0] in_days,
    output day_num_t    dnum_o
);

    localparam logic [16:0] MAX_YEAR17 = 17'(MAX_YEAR);

    typedef struct packed {
        logic        valid;
        logic        ok_range;
        logic [13:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [21:0] days;
        logic [7:0]  q100;
    } st1_t;

    typedef struct packed {
        logic        valid;
        logic        bad;
        logic [22:0] base;
        logic [7:0]  c100;
        logic [5:0]  c400;
        logic [8:0]  doy;
        logic [21:0] days;
    } st2_t;

    st1_t     s1_reg, s1_next;
    st2_t     s2_reg, s2_next;
    day_num_t s3_reg, s3_next;

    logic [24:0] q100_prod;
    logic [13:0] hund;
    logic [13:0] rem100;
    logic        z100;
    logic        z400;
    logic        leap;
    logic [13:0] py;

    // Stage 1: year / 100 by reciprocal of (year / 4) / 25, range checks
    assign q100_prod = 25'(in_year[13:2]) * 25'(RECIP_25);

    always_comb begin
        s1_next.valid    = in_valid;
        s1_next.ok_range = (in_year != 14'd0) && ({3'b000, in_year} <= MAX_YEAR17) &&
                           (in_month != 4'd0) && (in_month <= 4'd12) && (in_day != 5'd0);
        s1_next.year     = in_year;
        s1_next.month    = in_month;
        s1_next.day      = in_day;
        s1_next.days     = in_days;
        s1_next.q100     = q100_prod[RECIP_25_SHIFT +: 8];
    end

    // Stage 2: leap rule, day check, year base and day of year
    assign hund   = 14'(s1_reg.q100) * 14'd100;
    assign rem100 = s1_reg.year - hund;
    assign z100   = (rem100 == 14'd0);
    assign z400   = z100 && (s1_reg.q100[1:0] == 2'b00);
    assign leap   = (s1_reg.year[1:0] == 2'b00) && (!z100 || z400);
    assign py     = s1_reg.year - 14'd1;

    always_comb begin
        s2_next.valid = s1_reg.valid;
        s2_next.bad   = !s1_reg.ok_range || (s1_reg.day > month_len(s1_reg.month, leap));
        s2_next.base  = 23'(py) * 23'(DAYS_PER_Y) + 23'(py[13:2]);
        s2_next.c100  = s1_reg.q100 - {7'd0, z100};
        s2_next.c400  = s1_reg.q100[7:2] - {5'd0, z400};
        s2_next.doy   = month_start(s1_reg.month - 4'd1, leap) + 9'(s1_reg.day) - 9'd1;
        s2_next.days  = s1_reg.days;
    end

    // Stage 3: sum into the day number
    always_comb begin
        s3_next.valid  = s2_reg.valid;
        s3_next.bad    = s2_reg.bad;
        s3_next.serial = SERIAL_W'(s2_reg.base) - SERIAL_W'(s2_reg.c100) +
                         SERIAL_W'(s2_reg.c400) + SERIAL_W'(s2_reg.doy) +
                         SERIAL_W'(s2_reg.days);
    end

    // Advance all stages together
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_reg.valid <= 1'b0;
            s2_reg.valid <= 1'b0;
            s3_reg.valid <= 1'b0;
        end else if (advance) begin
            s1_reg <= s1_next;
            s2_reg <= s2_next;
            s3_reg <= s3_next;
        end
    end

    assign dnum_o = s3_reg;

endmodule

// ===== rtl/gda_divide.sv =====
module gda_divide
    import gda_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     advance,
    input  day_num_t dnum_i,
    output ydec_t    ydec_o
);

    typedef struct packed {
        logic                valid;
        logic                bad;
        logic [SERIAL_W-1:0] serial;
        logic [6:0]          q_est;
    } st4_t;

    typedef struct packed {
        logic        valid;
        logic        bad;
        logic [6:0]  q400;
        logic [17:0] r400;
    } st5_t;

    typedef struct packed {
        logic        valid;
        logic        bad;
        logic [6:0]  q400;
        logic [1:0]  cent;
        logic [15:0] r100;
    } st6_t;

    typedef struct packed {
        logic        valid;
        logic        bad;
        logic [6:0]  q400;
        logic [1:0]  cent;
        logic [15:0] r100;
        logic [4:0]  quad;
    } st7_t;

    st4_t  s4_reg, s4_next;
    st5_t  s5_reg, s5_next;
    st6_t  s6_reg, s6_next;
    st7_t  s7_reg, s7_next;
    ydec_t s8_reg, s8_next;

    logic [37:0]         q_prod;
    logic [SERIAL_W-1:0] qmul;
    logic [SERIAL_W-1:0] rem;
    logic                rem_over;
    logic [31:0]         quad_prod;
    logic [15:0]         qmul4;
    logic [10:0]         r4;

    // Stage 4: estimate day number / 146097
    assign q_prod = 38'(dnum_i.serial) * 38'(RECIP_400Y);

    always_comb begin
        s4_next.valid  = dnum_i.valid;
        s4_next.bad    = dnum_i.bad;
        s4_next.serial = dnum_i.serial;
        s4_next.q_est  = q_prod[RECIP_400Y_SHIFT +: 7];
    end

    // Stage 5: remainder and one correction step
    assign qmul     = SERIAL_W'(s4_reg.q_est) * SERIAL_W'(DAYS_PER_400Y);
    assign rem      = s4_reg.serial - qmul;
    assign rem_over = (rem >= SERIAL_W'(DAYS_PER_400Y));

    always_comb begin
        s5_next.valid = s4_reg.valid;
        s5_next.bad   = s4_reg.bad;
        s5_next.q400  = s4_reg.q_est + {6'd0, rem_over};
        s5_next.r400  = rem_over ? 18'(rem - SERIAL_W'(DAYS_PER_400Y)) : 18'(rem);
    end

    // Stage 6: centuries within the 400-year cycle, last one absorbs the leap day
    always_comb begin
        s6_next.valid = s5_reg.valid;
        s6_next.bad   = s5_reg.bad;
        s6_next.q400  = s5_reg.q400;
        if (s5_reg.r400 >= 18'(3 * DAYS_PER_100Y)) begin
            s6_next.cent = 2'd3;
            s6_next.r100 = 16'(s5_reg.r400 - 18'(3 * DAYS_PER_100Y));
        end else if (s5_reg.r400 >= 18'(2 * DAYS_PER_100Y)) begin
            s6_next.cent = 2'd2;
            s6_next.r100 = 16'(s5_reg.r400 - 18'(2 * DAYS_PER_100Y));
        end else if (s5_reg.r400 >= 18'(DAYS_PER_100Y)) begin
            s6_next.cent = 2'd1;
            s6_next.r100 = 16'(s5_reg.r400 - 18'(DAYS_PER_100Y));
        end else begin
            s6_next.cent = 2'd0;
            s6_next.r100 = 16'(s5_reg.r400);
        end
    end

    // Stage 7: four-year cycles by reciprocal
    assign quad_prod = 32'(s6_reg.r100) * 32'(RECIP_4Y);

    always_comb begin
        s7_next.valid = s6_reg.valid;
        s7_next.bad   = s6_reg.bad;
        s7_next.q400  = s6_reg.q400;
        s7_next.cent  = s6_reg.cent;
        s7_next.r100  = s6_reg.r100;
        s7_next.quad  = quad_prod[RECIP_4Y_SHIFT +: 5];
    end

    // Stage 8: years within the four-year cycle, last one absorbs the leap day
    assign qmul4 = 16'(s7_reg.quad) * 16'(DAYS_PER_4Y);
    assign r4    = 11'(s7_reg.r100 - qmul4);

    always_comb begin
        s8_next.valid = s7_reg.valid;
        s8_next.bad   = s7_reg.bad;
        s8_next.q400  = s7_reg.q400;
        s8_next.cent  = s7_reg.cent;
        s8_next.quad  = s7_reg.quad;
        if (r4 >= 11'(3 * DAYS_PER_Y)) begin
            s8_next.yr  = 2'd3;
            s8_next.doy = 9'(r4 - 11'(3 * DAYS_PER_Y));
        end else if (r4 >= 11'(2 * DAYS_PER_Y)) begin
            s8_next.yr  = 2'd2;
            s8_next.doy = 9'(r4 - 11'(2 * DAYS_PER_Y));
        end else if (r4 >= 11'(DAYS_PER_Y)) begin
            s8_next.yr  = 2'd1;
            s8_next.doy = 9'(r4 - 11'(DAYS_PER_Y));
        end else begin
            s8_next.yr  = 2'd0;
            s8_next.doy = 9'(r4);
        end
    end

    // Advance all stages together
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s4_reg.valid <= 1'b0;
            s5_reg.valid <= 1'b0;
            s6_reg.valid <= 1'b0;
            s7_reg.valid <= 1'b0;
            s8_reg.valid <= 1'b0;
        end else if (advance) begin
            s4_reg <= s4_next;
            s5_reg <= s5_next;
            s6_reg <= s6_next;
            s7_reg <= s7_next;
            s8_reg <= s8_next;
        end
    end

    assign ydec_o = s8_reg;

endmodule

// ===== rtl/gda_calendar.sv =====
module gda_calendar
    import gda_pkg::*;
#(
    parameter int unsigned MAX_YEAR = 9999
) (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    advance,
    input  ydec_t   ydec_i,
    output result_t res_o
);

    localparam logic [15:0] MAX_YEAR16  = 16'(MAX_YEAR);
    localparam logic [15:0] YEARS_400   = 16'd400;
    localparam logic [15:0] YEARS_100   = 16'd100;
    localparam logic [15:0] YEARS_4     = 16'd4;
    localparam logic [4:0]  LAST_QUAD   = 5'd24;

    result_t     res_reg, res_next;
    logic [15:0] year16;
    logic        leap;
    logic [3:0]  mon_idx;
    logic [8:0]  day_off;

    // Rebuild the year; leap years end a four-year cycle, except a century
    // that does not close the 400-year cycle
    assign year16 = 16'(ydec_i.q400) * YEARS_400 + 16'(ydec_i.cent) * YEARS_100 +
                    16'(ydec_i.quad) * YEARS_4 + 16'(ydec_i.yr) + 16'd1;
    assign leap   = (ydec_i.yr == 2'd3) && ((ydec_i.quad != LAST_QUAD) || (ydec_i.cent == 2'd3));

    // Find the month: last one whose start does not pass the day of year
    always_comb begin
        mon_idx = 4'd0;
        for (int i = 1; i < 12; i++) begin
            if (ydec_i.doy >= month_start(4'(i), leap)) begin
                mon_idx = 4'(i);
            end
        end
    end

    assign day_off = ydec_i.doy - month_start(mon_idx, leap);

    // Select the status and clear the fields of a failed item
    always_comb begin
        res_next.valid = ydec_i.valid;
        if (ydec_i.bad) begin
            res_next.status = STATUS_BAD_DATE;
            res_next.year   = 14'd0;
            res_next.month  = 4'd0;
            res_next.day    = 5'd0;
        end else if (year16 > MAX_YEAR16) begin
            res_next.status = STATUS_RANGE;
            res_next.year   = 14'd0;
            res_next.month  = 4'd0;
            res_next.day    = 5'd0;
        end else begin
            res_next.status = STATUS_OK;
            res_next.year   = year16[13:0];
            res_next.month  = mon_idx + 4'd1;
            res_next.day    = 5'(day_off) + 5'd1;
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            res_reg.valid <= 1'b0;
        end else if (advance) begin
            res_reg <= res_next;
        end
    end

    assign res_o = res_reg;

endmodule

// ===== rtl/gregorian_date_add_days.sv =====
// Gregorian date plus a day count.
// Input stream s_*: one item is a start date (year, month, day) and a count of
// days to add; it is taken at a rising edge where s_tvalid and s_tready are high.
// Output stream m_*: one item per input item, in order, with the resulting date
// and a status: 0 ok, 1 invalid start date, 2 result past MAX_YEAR. A failed
// item carries zero year, month and day.
// Nine register stages: three stages turn the date into a day number, five
// stages split it into 400-, 100-, 4- and 1-year cycles, one stage finds month
// and day and drives the output register.
// Throughput is one item per cycle unless the receiver stalls; every stage is a
// register and no unit is shared between items.
// When the receiver stalls with a result waiting, the whole pipeline holds and
// s_tready drops in the same cycle; nothing is lost or repeated.
// Reset (aresetn low at a clock edge) empties the pipeline; items in flight are
// dropped and m_tvalid is low afterward.
module gregorian_date_add_days
    import gda_pkg::*;
#(
    parameter int unsigned MAX_YEAR = 9999
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // start_year[13:0], start_month[17:14], start_day[22:18],
    // days_elapsed[44:23], zero [47:45]
    input  logic [47:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // end_year[13:0], end_month[17:14], end_day[22:18], status[24:23],
    // zero [31:25]
    output logic [31:0] m_tdata
);

    logic     advance;
    day_num_t dnum;
    ydec_t    ydec;
    result_t  res;

    // Hold the whole pipeline while a result waits
    assign advance  = !res.valid || m_tready;
    assign s_tready = advance;

    gda_serial #(
        .MAX_YEAR (MAX_YEAR)
    ) u_serial (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .advance  (advance),
        .in_valid (s_tvalid),
        .in_year  (s_tdata[13:0]),
        .in_month (s_tdata[17:14]),
        .in_day   (s_tdata[22:18]),
        .in_days  (s_tdata[44:23]),
        .dnum_o   (dnum)
    );

    gda_divide u_divide (
        .aclk    (aclk),
        .aresetn (aresetn),
        .advance (advance),
        .dnum_i  (dnum),
        .ydec_o  (ydec)
    );

    gda_calendar #(
        .MAX_YEAR (MAX_YEAR)
    ) u_calendar (
        .aclk    (aclk),
        .aresetn (aresetn),
        .advance (advance),
        .ydec_i  (ydec),
        .res_o   (res)
    );

    assign m_tvalid = res.valid;
    assign m_tdata  = {7'd0, res.status, res.day, res.month, res.year};

`ifndef NO_ASSERTIONS
    // Failed items carry no date
    a_fail_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tdata[24:23] != STATUS_OK)) |-> (m_tdata[22:0] == 23'd0))
        else $error("failed item carries a nonzero date");

    // Good items carry a date in range
    a_ok_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tdata[24:23] == STATUS_OK)) |->
        ((m_tdata[17:14] >= 4'd1) && (m_tdata[17:14] <= 4'd12) &&
         (m_tdata[22:18] >= 5'd1) && (m_tdata[22:18] <= 5'd31) &&
         ((MAX_YEAR > 16383) || (m_tdata[13:0] != 14'd0))))
        else $error("good item carries a date out of range");

    // Reset empties the pipeline
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    // Status is never an unused code
    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[24:23] != 2'b11))
        else $error("unused status code on output");
`endif

endmodule
